// ----- rtl/smss_pkg.sv -----
// Shared constants for the sorted matrix staircase search block.
// Holds operation codes, register indexes and field widths.
// No dependencies.
package smss_pkg;

  localparam int unsigned DEF_MAX_ROWS = 16;
  localparam int unsigned DEF_MAX_COLS = 16;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned PADDR_W = 3;

  // Operation codes carried by an input beat.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register select, taken from paddr bit 2.
  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  localparam logic [POS_W-1:0] POS_NONE = '1;

endpackage

// ----- rtl/smss_ram.sv -----
// Element store for the staircase search: one write port, one read port.
// Read data is registered. Uses smss_pkg.
module smss_ram import smss_pkg::*; #(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  localparam int unsigned RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [RIW-1:0]           wr_row_i,
  input  logic [CIW-1:0]           wr_col_i,
  input  logic signed [DATA_W-1:0] wr_data_i,
  input  logic                     rd_en_i,
  input  logic [RIW-1:0]           rd_row_i,
  input  logic [CIW-1:0]           rd_col_i,
  output logic signed [DATA_W-1:0] rd_data_o
);

  logic signed [DATA_W-1:0] mem_q [MAX_ROWS][MAX_COLS];
  logic signed [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i][wr_col_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i][rd_col_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/sorted_matrix_staircase_search.sv -----
// Top level of the sorted matrix staircase search: handshakes, APB registers
// and the walk controller. Uses smss_pkg and smss_ram.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_stall_o  op, row_index, col_index,
//                                               element_value, search_key
//   out       output     out_valid_o/out_stall_i found, found_row, found_col
//   config    APB        psel/penable/pready    rows_in_use (0x0), cols_in_use (0x4)
//
// A search reads at most rows_in_use + cols_in_use - 1 elements, one element
// a cycle from the single read port of the element store. An empty region
// skips the walk and goes straight to the result. Reset clears the registers
// to 16 and empties the result stage; the store keeps no reset. One item is
// in work at a time; a result waiting on out_stall_i is held, and holds the
// walk in its final state until it is taken.
module sorted_matrix_staircase_search import smss_pkg::*; #(
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [DATA_W-1:0] element_value_i,
  input  logic signed [DATA_W-1:0] search_key_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     found_o,
  output logic signed [POS_W-1:0]  found_row_o,
  output logic signed [POS_W-1:0]  found_col_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] rows_q, cols_q;
  logic [CNT_W-1:0] nrows_in, ncols_in;
  logic [CNT_W-1:0] nrows_q, nrows_d;
  logic [CNT_W-1:0] x_q, x_d;
  logic [CNT_W-1:0] y_q, y_d;
  logic signed [DATA_W-1:0] key_q, key_d;

  logic             res_found_q, res_found_d;
  logic [POS_W-1:0] res_row_q, res_row_d;
  logic [POS_W-1:0] res_col_q, res_col_d;

  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [POS_W-1:0] out_row_q, out_row_d;
  logic [POS_W-1:0] out_col_q, out_col_d;

  logic                     in_accept, cfg_write;
  logic                     wr_en, rd_en;
  logic [RIW-1:0]           wr_row, rd_row;
  logic [CIW-1:0]           wr_col, rd_col;
  logic signed [DATA_W-1:0] rd_data;
  logic [CNT_W-1:0]         rd_x, rd_y;
  logic                     elem_lt, elem_gt;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CNT_W'(16);
      cols_q <= CNT_W'(16);
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ROWS_IN_USE: rows_q <= pwdata[CNT_W-1:0];
        REG_COLS_IN_USE: cols_q <= pwdata[CNT_W-1:0];
        default:         rows_q <= rows_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ROWS_IN_USE: prdata[CNT_W-1:0] = rows_q;
      REG_COLS_IN_USE: prdata[CNT_W-1:0] = cols_q;
      default:         prdata = '0;
    endcase
  end

  // Region in use, saturated to the size of the store.
  assign nrows_in = (32'(rows_q) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : rows_q;
  assign ncols_in = (32'(cols_q) > MAX_COLS) ? CNT_W'(MAX_COLS) : cols_q;

  // The input side is stalled for the whole walk, so no write can land on
  // the store while it is being read.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign wr_en  = in_accept && (op_i == OP_WRITE) &&
                  (32'(row_index_i) < MAX_ROWS) && (32'(col_index_i) < MAX_COLS);
  assign wr_row = RIW'(row_index_i);
  assign wr_col = CIW'(col_index_i);

  assign elem_lt = (rd_data < key_q);
  assign elem_gt = (rd_data > key_q);

  always_comb begin
    state_d     = state_q;
    nrows_d     = nrows_q;
    x_d         = x_q;
    y_d         = y_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_row_d   = res_row_q;
    res_col_d   = res_col_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_found_d = out_found_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    rd_en       = 1'b0;
    rd_x        = '0;
    rd_y        = ncols_in;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (op_i == OP_SEARCH)) begin
          key_d       = search_key_i;
          nrows_d     = nrows_in;
          x_d         = '0;
          y_d         = ncols_in;
          res_found_d = 1'b0;
          res_row_d   = POS_NONE;
          res_col_d   = POS_NONE;
          if ((nrows_in == '0) || (ncols_in == '0)) begin
            state_d = ST_DONE;
          end else begin
            // First element: top-right corner of the region.
            rd_en   = 1'b1;
            rd_x    = '0;
            rd_y    = ncols_in;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (elem_lt) begin
          x_d = x_q + CNT_W'(1);
        end else if (elem_gt) begin
          y_d = y_q - CNT_W'(1);
        end
        if (!elem_lt && !elem_gt) begin
          res_found_d = 1'b1;
          res_row_d   = x_q;
          res_col_d   = y_q - CNT_W'(1);
          state_d     = ST_DONE;
        end else if ((x_d >= nrows_q) || (y_d == '0)) begin
          state_d = ST_DONE;
        end else begin
          rd_en = 1'b1;
          rd_x  = x_d;
          rd_y  = y_d;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_row_d   = res_row_q;
          out_col_d   = res_col_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // y counts columns plus one, so the column read is y - 1.
  assign rd_row = RIW'(rd_x);
  assign rd_col = CIW'(rd_y - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nrows_q     <= nrows_d;
    x_q         <= x_d;
    y_q         <= y_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_row_q   <= res_row_d;
    res_col_q   <= res_col_d;
    out_found_q <= out_found_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign found_row_o = out_row_q;
  assign found_col_o = out_col_q;

  smss_ram #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_row_i  (wr_row),
    .wr_col_i  (wr_col),
    .wr_data_i (element_value_i),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_col_i  (rd_col),
    .rd_data_o (rd_data)
  );

endmodule
